@@ hdl/gesture_hold_confirm_unit_defines.svh @@
// Assertion macros shared by the gesture hold confirm unit.
`ifndef GESTURE_HOLD_CONFIRM_UNIT_DEFINES_SVH
`define GESTURE_HOLD_CONFIRM_UNIT_DEFINES_SVH

`ifndef SYNTH
`define GHC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");
`define GHC_ASSERT_IMPL(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("implication failed");
`define GHC_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("next-cycle check failed");
`else
`define GHC_ASSERT(label, prop)
`define GHC_ASSERT_IMPL(label, cond, expr)
`define GHC_ASSERT_NEXT(label, cond, expr)
`endif

`endif

@@ hdl/ghc_pkg.sv @@
`default_nettype none

package ghc_pkg;

    localparam logic [2:0]        GESTURE_NIL    = 3'd7;
    localparam logic signed [3:0] CONFIRMED_NONE = -4'sd1;
    localparam logic [3:0]        GESTURE_ABORT  = 4'd0;
    localparam logic [3:0]        GESTURE_MAX    = 4'd4;
    localparam logic [15:0]       HOLD_TIME_RESET  = 16'd1000;
    localparam logic [15:0]       LOST_GRACE_RESET = 16'd500;
    localparam int                PADDR_W = 3;
    localparam int                PDATA_W = 32;

    typedef enum logic [0:0] {
        REG_HOLD_TIME  = 1'b0,
        REG_LOST_GRACE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] hold_time_ms;
        logic [15:0] lost_grace_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0]       now_ms;
        logic              act_enable;
        logic signed [3:0] gesture;
        logic              hand_present;
        logic              controller_busy;
        logic              controller_accepts;
    } item_t;

    typedef struct packed {
        logic              abort_request;
        logic              fire_request;
        logic signed [3:0] confirmed_gesture;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/ghc_regs.sv @@
`default_nettype none

module ghc_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ghc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ghc_pkg::PDATA_W-1:0] pwdata,
    output logic      [ghc_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output ghc_pkg::cfg_t                    cfg
);
    import ghc_pkg::*;

    logic [15:0] hold_time_reg;
    logic [15:0] hold_time_next;
    logic [15:0] lost_grace_reg;
    logic [15:0] lost_grace_next;
    logic        wr_en;
    reg_idx_t    idx;

    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        hold_time_next  = hold_time_reg;
        lost_grace_next = lost_grace_reg;
        if (wr_en) begin
            case (idx)
                REG_HOLD_TIME:  hold_time_next  = pwdata[15:0];
                REG_LOST_GRACE: lost_grace_next = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_time_reg  <= HOLD_TIME_RESET;
            lost_grace_reg <= LOST_GRACE_RESET;
        end else begin
            hold_time_reg  <= hold_time_next;
            lost_grace_reg <= lost_grace_next;
        end
    end

    always_comb begin
        case (idx)
            REG_HOLD_TIME:  prdata = {16'd0, hold_time_reg};
            REG_LOST_GRACE: prdata = {16'd0, lost_grace_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.hold_time_ms  = hold_time_reg;
    assign cfg.lost_grace_ms = lost_grace_reg;

endmodule

`default_nettype wire

@@ hdl/ghc_in_stage.sv @@
`default_nettype none

module ghc_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire ghc_pkg::item_t s_item,
    input  wire logic           advance,
    output logic                item_valid,
    output ghc_pkg::item_t      item
);
    import ghc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

@@ hdl/ghc_core.sv @@
`default_nettype none
`include "gesture_hold_confirm_unit_defines.svh"

module ghc_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire ghc_pkg::cfg_t  cfg,
    input  wire logic           advance,
    input  wire ghc_pkg::item_t item,
    output ghc_pkg::result_t    result
);
    import ghc_pkg::*;

    logic [2:0]  cand_reg;
    logic [2:0]  cand_next;
    logic [31:0] hold_start_reg;
    logic [31:0] hold_start_next;
    logic        hold_valid_reg;
    logic        hold_valid_next;
    logic [31:0] lost_start_reg;
    logic [31:0] lost_start_next;
    logic        lost_valid_reg;
    logic        lost_valid_next;
    logic [2:0]  last_fired_reg;
    logic [2:0]  last_fired_next;

    logic [3:0]  graw;
    logic [2:0]  g3;
    logic        frame_live;
    logic [31:0] lost_eff;
    logic [31:0] hold_eff;
    logic [31:0] lost_diff;
    logic [31:0] hold_diff;
    logic        gone;
    logic        held;
    logic        confirmed;

    assign graw       = item.gesture;
    assign g3         = graw[2:0];
    assign frame_live = item.act_enable && (graw <= GESTURE_MAX);
    assign lost_eff   = lost_valid_reg ? lost_start_reg : item.now_ms;
    assign hold_eff   = hold_valid_reg ? hold_start_reg : item.now_ms;
    assign lost_diff  = item.now_ms - lost_eff;
    assign hold_diff  = item.now_ms - hold_eff;
    assign gone       = !item.hand_present && (lost_diff >= {16'd0, cfg.lost_grace_ms});
    assign held       = hold_diff >= {16'd0, cfg.hold_time_ms};

    always_comb begin
        cand_next       = cand_reg;
        hold_start_next = hold_start_reg;
        hold_valid_next = hold_valid_reg;
        lost_start_next = lost_start_reg;
        lost_valid_next = lost_valid_reg;
        last_fired_next = last_fired_reg;
        confirmed       = 1'b0;
        result.abort_request     = 1'b0;
        result.fire_request      = 1'b0;
        result.confirmed_gesture = CONFIRMED_NONE;
        if (!frame_live) begin
            last_fired_next = GESTURE_NIL;
        end else if (graw == GESTURE_ABORT) begin
            last_fired_next      = GESTURE_NIL;
            result.abort_request = 1'b1;
        end else begin
            if (item.hand_present) begin
                lost_valid_next = 1'b0;
            end else begin
                lost_start_next = lost_eff;
                lost_valid_next = 1'b1;
            end
            if (gone) begin
                cand_next       = GESTURE_NIL;
                hold_valid_next = 1'b0;
            end else if (g3 != cand_reg) begin
                cand_next       = g3;
                hold_start_next = item.now_ms;
                hold_valid_next = 1'b1;
            end else begin
                hold_start_next = hold_eff;
                hold_valid_next = 1'b1;
                confirmed       = held;
            end
            if (!confirmed) begin
                last_fired_next = GESTURE_NIL;
            end else begin
                result.confirmed_gesture = {1'b0, g3};
                if ((g3 != last_fired_reg) && !item.controller_busy) begin
                    result.fire_request = 1'b1;
                    if (item.controller_accepts) begin
                        last_fired_next = g3;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg       <= GESTURE_NIL;
            hold_valid_reg <= 1'b0;
            lost_valid_reg <= 1'b0;
            last_fired_reg <= GESTURE_NIL;
        end else if (advance) begin
            cand_reg       <= cand_next;
            hold_valid_reg <= hold_valid_next;
            lost_valid_reg <= lost_valid_next;
            last_fired_reg <= last_fired_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hold_start_reg <= hold_start_next;
            lost_start_reg <= lost_start_next;
        end
    end

    `GHC_ASSERT_NEXT(a_clear_on_idle_frame, advance && !frame_live,
        last_fired_reg == GESTURE_NIL)
    `GHC_ASSERT_NEXT(a_mark_on_accept,
        advance && result.fire_request && item.controller_accepts,
        last_fired_reg == $past(g3))
    `GHC_ASSERT_NEXT(a_lost_timer_armed, advance && frame_live && (graw != GESTURE_ABORT)
        && !item.hand_present, lost_valid_reg)
    `GHC_ASSERT(a_mark_needs_candidate,
        (last_fired_reg == GESTURE_NIL) || (last_fired_reg == cand_reg))

endmodule

`default_nettype wire

@@ hdl/ghc_out_stage.sv @@
`default_nettype none
`include "gesture_hold_confirm_unit_defines.svh"

module ghc_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             item_valid,
    input  wire ghc_pkg::result_t result,
    output logic                  advance,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ghc_pkg::result_t      m_result
);
    import ghc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign advance = item_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    `GHC_ASSERT_IMPL(a_abort_excludes_fire, valid_reg,
        !(result_reg.abort_request && result_reg.fire_request))
    `GHC_ASSERT_IMPL(a_fire_has_gesture, valid_reg && result_reg.fire_request,
        result_reg.confirmed_gesture != CONFIRMED_NONE)

endmodule

`default_nettype wire

@@ hdl/gesture_hold_confirm_unit.sv @@
// Gesture hold confirm unit.
// Input channel (s_valid/s_ready): one word per classified frame with time stamp,
// enable flag, gesture id, hand presence and the action unit's busy/accept flags.
// Result channel (m_valid/m_ready): one word per input word with abort request,
// fire request and the confirmed gesture (-1 when none), in input order.
// Configuration: APB port, hold_time_ms at address 0, lost_grace_ms at address 4,
// 16 bits each; pready is always high. Write only while the block is idle.
// Processing: an accepted word waits in the input register and moves into the
// result register when that one is empty or m_ready is high; m_valid then rises.
// Throughput: one word per cycle if m_ready is high; the per-frame state update is
// a single pass of two 32-bit subtract-and-compare paths between input and result registers.
// Reset (aresetn low, synchronous): both stages empty, no candidate, no hold,
// no lost timer, no last-fired mark, registers back to 1000 and 500.
// Receiver stall: the result register holds, the input register takes one more word
// only if it is empty, and s_ready then stays low until m_ready returns.
`default_nettype none

module gesture_hold_confirm_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ghc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ghc_pkg::PDATA_W-1:0] pwdata,
    output logic      [ghc_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [31:0]                 s_now_ms,
    input  wire logic                        s_act_enable,
    input  wire logic signed [3:0]           s_gesture,
    input  wire logic                        s_hand_present,
    input  wire logic                        s_controller_busy,
    input  wire logic                        s_controller_accepts,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_abort_request,
    output logic                             m_fire_request,
    output logic signed [3:0]                m_confirmed_gesture
);
    import ghc_pkg::*;

    cfg_t    cfg;
    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    result_t m_result;

    assign s_item.now_ms             = s_now_ms;
    assign s_item.act_enable         = s_act_enable;
    assign s_item.gesture            = s_gesture;
    assign s_item.hand_present       = s_hand_present;
    assign s_item.controller_busy    = s_controller_busy;
    assign s_item.controller_accepts = s_controller_accepts;

    ghc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ghc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ghc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    ghc_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

    assign m_abort_request     = m_result.abort_request;
    assign m_fire_request      = m_result.fire_request;
    assign m_confirmed_gesture = m_result.confirmed_gesture;

endmodule

`default_nettype wire
